@@ rtl/line_keyword_command_recognizer_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef LINE_KEYWORD_COMMAND_RECOGNIZER_CORE_ASSERT_SVH
`define LINE_KEYWORD_COMMAND_RECOGNIZER_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is active.
`define LKCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkcr: implication check failed");

// Next-cycle implication, masked while reset is active.
`define LKCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkcr: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define LKCR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lkcr: reset behaviour check failed");

`endif

@@ rtl/lkcr_pkg.sv @@
package lkcr_pkg;

  // Request modes
  localparam logic MODE_RX    = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Control characters
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_CR = 8'h0D;

  // Command codes
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_UP      = 4'd1;
  localparam logic [3:0] CMD_DOWN    = 4'd2;
  localparam logic [3:0] CMD_CONFIRM = 4'd3;
  localparam logic [3:0] CMD_BACK    = 4'd4;
  localparam logic [3:0] CMD_START   = 4'd5;
  localparam logic [3:0] CMD_PAUSE   = 4'd6;
  localparam logic [3:0] CMD_UPLOAD  = 4'd7;
  localparam logic [3:0] CMD_CLEAR   = 4'd8;
  localparam logic [3:0] CMD_REPORT  = 4'd9;

  // Keyword table: entries held for matching, longest keyword is 7
  localparam int KW_COUNT = 9;
  localparam int KW_MAX   = 8;
  localparam int KW_IDX_W = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [KW_MAX-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "P",   "U"},
    {8'h00, 8'h00, 8'h00, 8'h00, "N",   "W",   "O",   "D"},
    {8'h00, "M",   "R",   "I",   "F",   "N",   "O",   "C"},
    {8'h00, 8'h00, 8'h00, 8'h00, "K",   "C",   "A",   "B"},
    {8'h00, 8'h00, 8'h00, "T",   "R",   "A",   "T",   "S"},
    {8'h00, 8'h00, 8'h00, "E",   "S",   "U",   "A",   "P"},
    {8'h00, 8'h00, "D",   "A",   "O",   "L",   "P",   "U"},
    {8'h00, 8'h00, 8'h00, "R",   "A",   "E",   "L",   "C"},
    {8'h00, 8'h00, "T",   "R",   "O",   "P",   "E",   "R"}
  };

  localparam logic [KW_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd7, 3'd4, 3'd5, 3'd5, 3'd6, 3'd5, 3'd6
  };

  // Request and result payloads
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] command;
    logic       command_pending;
    logic       line_done;
  } result_t;

endpackage

@@ rtl/lkcr_if.sv @@
// Request channel
interface lkcr_item_if import lkcr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Result channel
interface lkcr_result_if import lkcr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic       command_pending;
  logic       line_done;

  modport source (output valid, output command, output command_pending,
                  output line_done, input ready);
  modport sink   (input valid, input command, input command_pending,
                  input line_done, output ready);
endinterface

@@ rtl/line_keyword_command_recognizer_core.sv @@
// Line keyword recogniser. Each request carries a received byte (mode 0) or
// a clear (mode 1) and yields exactly one result: the current command code
// (0 none, 1..9 for UP, DOWN, CONFIRM, BACK, START, PAUSE, UPLOAD, CLEAR,
// REPORT), the pending flag and a line-done strobe. A line ends on CR LF; a
// line that matches no keyword keeps the previous command but still sets
// pending. A line that fills LINE_DEPTH-1 bytes without ending is dropped.
// One request is taken every cycle; a result is offered once its request
// has passed the request register and then the result register, with the
// keyword compare done in a single pass between them. Back-pressure on the
// result side stalls the request side only when both registers are full.
module line_keyword_command_recognizer_core import lkcr_pkg::*; #(
  parameter int LINE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lkcr_item_if.sink            in_if,
  lkcr_result_if.source        out_if
);

  logic    in_v_r, in_v_nxt;
  item_t   in_item_r;
  logic    out_v_r, out_v_nxt;
  result_t out_res_r;
  result_t res_nxt;
  logic    in_fire;
  logic    advance;

  // Handshake and pipeline advance
  assign advance     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_v_nxt    = in_fire || (in_v_r && !advance);
  assign out_v_nxt   = advance || (out_v_r && !out_if.ready);

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.mode    <= in_if.mode;
      in_item_r.rx_byte <= in_if.rx_byte;
    end
  end

  lkcr_line_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (in_item_r),
    .res_nxt (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.command         = out_res_r.command;
  assign out_if.command_pending = out_res_r.command_pending;
  assign out_if.line_done       = out_res_r.line_done;

endmodule

@@ rtl/lkcr_kw_match.sv @@
module lkcr_kw_match import lkcr_pkg::*; (
  input  byte_t [KW_MAX-1:0]  line_bytes,
  input  logic                len_ok,
  input  logic [KW_IDX_W-1:0] line_len,
  output logic [3:0]          code
);

  logic [KW_COUNT-1:0] hit;

  // One comparator per keyword: length first, then each used position
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = len_ok && (line_len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX; i++) begin
        if (i < int'(KW_LEN[k]) && line_bytes[i] != KW_TEXT[k][i]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // Keywords are distinct, so at most one hit; lowest wins regardless
  always_comb begin
    code = CMD_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code = 4'(k + 1);
      end
    end
  end

endmodule

@@ rtl/lkcr_line_ctrl.sv @@
module lkcr_line_ctrl import lkcr_pkg::*; #(
  parameter int LINE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res_nxt
);

  localparam int FILL_W = $clog2(LINE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LINE_DEPTH - 1);

  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               prev_cr_r, prev_cr_nxt;
  logic [3:0]         cmd_r, cmd_nxt;
  logic               pend_r, pend_nxt;
  byte_t [KW_MAX-1:0] store_r;

  logic               is_rx;
  logic [FILL_W-1:0]  fill_inc;
  logic [FILL_W-1:0]  line_len;
  logic               len_ok;
  logic               line_end;
  logic               store_wr;
  logic [3:0]         code;

  // Line end: LF with a CR as the previous received byte
  assign is_rx    = (item.mode == MODE_RX);
  assign fill_inc = fill_r + 1'b1;
  assign line_len = fill_r - 1'b1;
  assign len_ok   = ((line_len >> KW_IDX_W) == '0);
  assign line_end = is_rx && (item.rx_byte == CHR_LF) && (fill_r != '0) && prev_cr_r;
  // Only the head of the line can ever match a keyword
  assign store_wr = is_rx && ((fill_r >> KW_IDX_W) == '0);

  lkcr_kw_match u_match (
    .line_bytes (store_r),
    .len_ok     (len_ok),
    .line_len   (line_len[KW_IDX_W-1:0]),
    .code       (code)
  );

  // Next state for one request
  always_comb begin
    fill_nxt    = fill_r;
    prev_cr_nxt = prev_cr_r;
    cmd_nxt     = cmd_r;
    pend_nxt    = pend_r;
    if (!is_rx) begin
      cmd_nxt  = CMD_NONE;
      pend_nxt = 1'b0;
    end else begin
      prev_cr_nxt = (item.rx_byte == CHR_CR);
      if (line_end) begin
        pend_nxt = 1'b1;
        if (code != CMD_NONE) begin
          cmd_nxt = code;
        end
      end
      // Completed line or full buffer both restart the line
      if (line_end || fill_inc == FILL_LAST) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  assign res_nxt.command         = cmd_nxt;
  assign res_nxt.command_pending = pend_nxt;
  assign res_nxt.line_done       = line_end;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      prev_cr_r <= 1'b0;
      cmd_r     <= CMD_NONE;
      pend_r    <= 1'b0;
    end else if (step) begin
      fill_r    <= fill_nxt;
      prev_cr_r <= prev_cr_nxt;
      cmd_r     <= cmd_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Line head store, no reset
  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      store_r[fill_r[KW_IDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule

@@ rtl/lkcr_checker.sv @@
`include "line_keyword_command_recognizer_core_assert.svh"

module lkcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] command,
  input logic       command_pending,
  input logic       line_done
);

  // A stalled result holds
  `LKCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(command) && $stable(command_pending) && $stable(line_done))

  // A completed line always leaves a pending command
  `LKCR_ASSERT_IMPLY(a_done_pending, clk, rst_n, out_valid && line_done, command_pending)

  // Command code stays within the keyword range
  `LKCR_ASSERT_IMPLY(a_cmd_range, clk, rst_n, out_valid, command <= 4'd9)

  // Request side only stalls behind a blocked result
  `LKCR_ASSERT_IMPLY(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready)

  // Reset empties the result register
  `LKCR_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind line_keyword_command_recognizer_core lkcr_checker u_lkcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .command         (out_if.command),
  .command_pending (out_if.command_pending),
  .line_done       (out_if.line_done)
);

@@ tb/sv/tb_line_keyword_command_recognizer_core.sv @@
module tb_line_keyword_command_recognizer_core;
  import lkcr_pkg::*;

  localparam int LINE_DEPTH   = 16;
  localparam int REQ_TARGET   = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS   = 20;

  logic clk;
  logic rst_n;

  lkcr_item_if   req_ch ();
  lkcr_result_if res_ch ();

  line_keyword_command_recognizer_core #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  always #10 clk = ~clk;

  // Keyword spellings, index k gives command code k+1
  string kw_names [9] = '{"UP", "DOWN", "CONFIRM", "BACK", "START", "PAUSE",
                          "UPLOAD", "CLEAR", "REPORT"};

  // Recogniser shadow state
  logic [7:0] line_buf [LINE_DEPTH];
  int         fill;
  logic [3:0] cur_cmd;
  logic       pend;

  item_t   req_q  [$];
  result_t want_q [$];

  int unsigned n_total;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_lines;
  int unsigned n_clears;
  int unsigned n_errors;
  int unsigned cycles;
  logic [9:0]  kw_seen;
  logic        req_took;

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  // Code of the keyword equal to the first len stored bytes, or none
  function automatic logic [3:0] lookup_keyword(int len);
    logic same;
    for (int k = 0; k < 9; k++) begin
      if (kw_names[k].len() == len) begin
        same = 1'b1;
        for (int i = 0; i < len; i++)
          if (line_buf[i] != kw_names[k][i]) same = 1'b0;
        if (same) return 4'(k + 1);
      end
    end
    return CMD_NONE;
  endfunction

  // Advance the shadow state by one request and return the result it yields
  function automatic result_t apply_request(item_t it);
    result_t    r;
    logic [3:0] code;
    r.line_done = 1'b0;
    if (it.mode == MODE_CLEAR) begin
      cur_cmd = CMD_NONE;
      pend    = 1'b0;
      n_clears++;
    end else begin
      if (fill < LINE_DEPTH - 1) begin
        line_buf[fill] = it.rx_byte;
        fill++;
      end
      // CR LF ends the line; text before the CR is matched
      if (it.rx_byte == CHR_LF && fill > 1 && line_buf[fill-2] == CHR_CR) begin
        code = lookup_keyword(fill - 2);
        if (code != CMD_NONE) begin
          cur_cmd       = code;
          kw_seen[code] = 1'b1;
        end
        pend        = 1'b1;
        fill        = 0;
        r.line_done = 1'b1;
        n_lines++;
      end
      // full store without a line end drops the partial line
      if (fill >= LINE_DEPTH - 1) fill = 0;
    end
    r.command         = cur_cmd;
    r.command_pending = pend;
    return r;
  endfunction

  // Stimulus building
  task automatic push_req(logic mode, logic [7:0] b);
    item_t it;
    it.mode    = mode;
    it.rx_byte = b;
    req_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_req(MODE_RX, s[i]);
  endtask

  task automatic push_eol();
    push_req(MODE_RX, CHR_CR);
    push_req(MODE_RX, CHR_LF);
  endtask

  function automatic logic [7:0] rand_byte_no_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHR_LF) b = "A";
    return b;
  endfunction

  task automatic build_stimulus();
    string s;
    int    r;
    int    k;
    int    n;
    // directed opening
    push_text("UP");
    push_eol();
    push_req(MODE_CLEAR, 8'h00);
    push_text("REPORT");
    push_eol();
    push_eol();                         // empty line
    push_req(MODE_RX, CHR_LF);          // LF with no CR before it
    push_req(MODE_RX, 8'hFF);
    push_req(MODE_RX, 8'h00);           // zero byte is ordinary text
    push_text("UP");
    push_eol();
    push_req(MODE_CLEAR, 8'hFF);        // byte ignored on clear
    // random part: mostly well-formed lines
    while (req_q.size() < REQ_TARGET) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 8);
      if (r < 50) begin
        push_text(kw_names[k]);
        push_eol();
      end else if (r < 62) begin
        // near-miss keyword
        s = kw_names[k];
        case ($urandom_range(0, 2))
          0: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range("A", "Z"));
          1: s = s.substr(0, s.len() - 2);
          default: s = {s, "S"};
        endcase
        push_text(s);
        push_eol();
      end else if (r < 72) begin
        n = $urandom_range(0, 16);
        repeat (n) push_req(MODE_RX, 8'($urandom_range(0, 255)));
        push_eol();
      end else if (r < 80) begin
        push_req(MODE_CLEAR, 8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        // overlong line, then sometimes an ending
        n = $urandom_range(14, 22);
        repeat (n) push_req(MODE_RX, rand_byte_no_lf());
        if ($urandom_range(0, 1)) push_eol();
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) push_req(MODE_RX, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Idle percentages per phase of the run
  function automatic int send_idle_pct();
    if (n_sent < n_total / 3) return 29;
    if (n_sent < 2 * n_total / 3) return 82;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_sent < n_total / 3) return 82;
    if (n_sent < 2 * n_total / 3) return 29;
    return 0;
  endfunction

  // Request driver and result-side ready
  always @(negedge clk) begin : drive_requests
    item_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_took) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nxt = req_q.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.mode    <= nxt.mode;
          req_ch.rx_byte <= nxt.rx_byte;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // Result checker and request capture
  always @(posedge clk) begin : watch_channels
    result_t want;
    item_t   it;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_line_keyword_command_recognizer_core: FAIL");
      $finish;
    end else if (!rst_n) begin
      req_took <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (want_q.size() == 0) begin
          report_mismatch("result with nothing expected", res_ch.command, -1);
        end else begin
          want = want_q.pop_front();
          if (res_ch.command !== want.command)
            report_mismatch("command", res_ch.command, want.command);
          if (res_ch.command_pending !== want.command_pending)
            report_mismatch("command_pending", res_ch.command_pending,
                            want.command_pending);
          if (res_ch.line_done !== want.line_done)
            report_mismatch("line_done", res_ch.line_done, want.line_done);
        end
      end
      req_took <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        it.mode    = req_ch.mode;
        it.rx_byte = req_ch.rx_byte;
        want_q.push_back(apply_request(it));
        n_sent++;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_RX;
    req_ch.rx_byte = 8'h00;
    res_ch.ready   = 1'b0;
    req_took       = 1'b0;
    fill           = 0;
    cur_cmd        = CMD_NONE;
    pend           = 1'b0;
    kw_seen        = '0;
    for (int i = 0; i < LINE_DEPTH; i++) line_buf[i] = 8'h00;
    build_stimulus();
    n_total = req_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // wait until every request is in and every result is back
    while (!(req_q.size() == 0 && !req_ch.valid && want_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_q.size() != 0)
      report_mismatch("results never delivered", 0, want_q.size());

    $display("run: %0d requests, %0d results checked, %0d lines ended, %0d clears",
             n_sent, n_results, n_lines, n_clears);
    $display("run: keyword codes matched (bit per code) %b, %0d mismatches",
             kw_seen, n_errors);
    if (n_errors == 0)
      $display("tb_line_keyword_command_recognizer_core: PASS");
    else
      $display("tb_line_keyword_command_recognizer_core: FAIL");
    $finish;
  end

endmodule

@@ line_keyword_command_recognizer_core.f @@
+incdir+rtl
rtl/lkcr_pkg.sv
rtl/lkcr_if.sv
rtl/lkcr_kw_match.sv
rtl/lkcr_line_ctrl.sv
rtl/line_keyword_command_recognizer_core.sv
rtl/lkcr_checker.sv
tb/sv/tb_line_keyword_command_recognizer_core.sv
